// ----- rtl/vri_pkg.sv -----
// ----------------------------------------------------------------------------
// Video register interface package
// Shared types, register numbers, access codes and sizes for the CPU-facing
// register file of the video unit.
// ----------------------------------------------------------------------------
package vri_pkg;

    // Bus access codes carried in the op field. The third code is no access.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_NONE  = 2'd2;

    // Register numbers.
    localparam logic [2:0] REG_CONTROL  = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_SPR_ADDR = 3'd3;
    localparam logic [2:0] REG_SPR_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDRESS  = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Sizes.
    localparam int SPRITE_MEM_DEPTH = 256;
    localparam int SPR_ADDR_W       = $clog2(SPRITE_MEM_DEPTH);
    localparam int PAL_DEPTH        = 32;
    localparam int PAL_ADDR_W       = $clog2(PAL_DEPTH);
    localparam int VADDR_W          = 15;
    localparam int EXT_ADDR_W       = 14;

    // Addresses whose bits 13:8 are all ones fall in the palette.
    localparam logic [5:0] PAL_PAGE = 6'h3F;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic [7:0] vram_read_data;
        logic       vblank_start;
        logic       vblank_end;
        logic       sprite_zero_flag;
        logic       sprite_over_flag;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]            read_data;
        logic                  nmi_pulse;
        logic                  vram_write;
        logic [EXT_ADDR_W-1:0] vram_write_address;
        logic [7:0]            vram_write_byte;
        logic [7:0]            control_out;
        logic [7:0]            mask_out;
        logic [VADDR_W-1:0]    transfer_address_out;
        logic [VADDR_W-1:0]    current_address_out;
        logic [2:0]            fine_scroll_out;
    } out_beat_t;

    // Sprite memory control from the register logic.
    typedef struct packed {
        logic       load_addr;
        logic       write;
        logic [7:0] data;
    } spr_ctl_t;

endpackage

// ----- rtl/vri_in_if.sv -----
// ----------------------------------------------------------------------------
// Bus access channel
// Valid/ready channel that carries one CPU bus access beat.
// ----------------------------------------------------------------------------
interface vri_in_if
    import vri_pkg::*;
;
    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/vri_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface vri_out_if
    import vri_pkg::*;
;
    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/vri_sprite_mem.sv -----
// ----------------------------------------------------------------------------
// Sprite attribute memory
// Holds the sprite address register, the attribute memory with per-entry
// valid bits, and a registered read of the entry at the current address.
// ----------------------------------------------------------------------------
module vri_sprite_mem
    import vri_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  spr_ctl_t   ctl,
    output logic [7:0] rdata
);

    logic [7:0]            mem [SPRITE_MEM_DEPTH];
    logic [SPRITE_MEM_DEPTH-1:0] valid_reg;
    logic [SPR_ADDR_W-1:0] addr_reg;
    logic [SPR_ADDR_W-1:0] addr_next;
    logic [7:0]            rdata_reg;
    logic                  rvalid_reg;

    // A write always moves the address on, so the look-ahead read never
    // meets the entry written in the same cycle.
    always_comb
    begin
        addr_next = addr_reg;
        if (ctl.load_addr)
        begin
            addr_next = ctl.data[SPR_ADDR_W-1:0];
        end
        else if (ctl.write)
        begin
            addr_next = addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            addr_reg <= addr_next;
            if (ctl.write)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            rvalid_reg <= valid_reg[addr_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            mem[addr_reg] <= ctl.data;
        end
        rdata_reg <= mem[addr_next];
    end

    assign rdata = rvalid_reg ? rdata_reg : 8'h00;

endmodule

// ----- rtl/vri_core.sv -----
// ----------------------------------------------------------------------------
// Register core
// Register state, palette memory and the single-pass access logic that turns
// one bus access into one result beat.
// ----------------------------------------------------------------------------
module vri_core
    import vri_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  in_beat_t   item,
    input  logic [7:0] spr_rdata,
    output spr_ctl_t   spr_ctl,
    output out_beat_t  result
);

    logic [7:0]         latch_reg,   latch_next;
    logic [7:0]         control_reg, control_next;
    logic [7:0]         mask_reg,    mask_next;
    logic               vblank_reg,  vblank_next;
    logic               first_reg,   first_next;
    logic [VADDR_W-1:0] temp_reg,    temp_next;
    logic [VADDR_W-1:0] vaddr_reg,   vaddr_next;
    logic [2:0]         fine_reg,    fine_next;
    logic [7:0]         buffer_reg,  buffer_next;
    logic [7:0]         pal_reg [PAL_DEPTH];

    logic                  vblank_ev;
    logic [VADDR_W-1:0]    vaddr_step;
    logic [EXT_ADDR_W-1:0] ext_addr;
    logic                  in_pal;
    logic                  pal_wr;
    logic [PAL_ADDR_W-1:0] pal_idx;
    logic                  pal_mirror;
    logic [7:0]            rd;
    logic                  nmi;
    logic                  vw;
    spr_ctl_t              spr_req;

    assign vaddr_step = vaddr_reg + (control_reg[2] ? VADDR_W'(32) : VADDR_W'(1));
    assign ext_addr   = vaddr_reg[EXT_ADDR_W-1:0];
    assign in_pal     = (ext_addr[13:8] == PAL_PAGE);
    assign pal_idx    = ext_addr[PAL_ADDR_W-1:0];
    assign pal_mirror = (pal_idx[1:0] == 2'b00);

    always_comb
    begin
        latch_next   = latch_reg;
        control_next = control_reg;
        mask_next    = mask_reg;
        first_next   = first_reg;
        temp_next    = temp_reg;
        vaddr_next   = vaddr_reg;
        fine_next    = fine_reg;
        buffer_next  = buffer_reg;
        pal_wr       = 1'b0;
        rd           = 8'h00;
        vw           = 1'b0;
        spr_req      = '{load_addr: 1'b0, write: 1'b0, data: item.write_data};

        // Renderer events act before the access; the end event wins.
        vblank_ev = vblank_reg;
        if (item.vblank_start)
        begin
            vblank_ev = 1'b1;
        end
        if (item.vblank_end)
        begin
            vblank_ev = 1'b0;
        end
        vblank_next = vblank_ev;
        nmi         = item.vblank_start & control_reg[7];

        unique case (item.op)
            OP_READ:
            begin
                unique case (item.reg_select)
                    REG_CONTROL, REG_MASK:
                    begin
                        rd = latch_reg;
                    end
                    REG_STATUS:
                    begin
                        rd = {vblank_ev, item.sprite_zero_flag, item.sprite_over_flag,
                              latch_reg[4:0]};
                        vblank_next = 1'b0;
                        first_next  = 1'b1;
                    end
                    REG_SPR_DATA:
                    begin
                        rd = spr_rdata;
                    end
                    REG_DATA:
                    begin
                        rd          = in_pal ? pal_reg[pal_idx] : buffer_reg;
                        buffer_next = item.vram_read_data;
                        vaddr_next  = vaddr_step;
                    end
                    default:
                    begin
                        rd = 8'h00;
                    end
                endcase
                latch_next = rd;
            end
            OP_WRITE:
            begin
                latch_next = item.write_data;
                unique case (item.reg_select)
                    REG_CONTROL:
                    begin
                        if (vblank_ev && !control_reg[7] && item.write_data[7])
                        begin
                            nmi = 1'b1;
                        end
                        control_next = item.write_data;
                        temp_next    = {temp_reg[14:12], item.write_data[1:0], temp_reg[9:0]};
                    end
                    REG_MASK:
                    begin
                        mask_next = item.write_data;
                    end
                    REG_SPR_ADDR:
                    begin
                        spr_req.load_addr = 1'b1;
                    end
                    REG_SPR_DATA:
                    begin
                        spr_req.write = 1'b1;
                    end
                    REG_SCROLL:
                    begin
                        if (first_reg)
                        begin
                            temp_next = {temp_reg[14:5], item.write_data[7:3]};
                            fine_next = item.write_data[2:0];
                        end
                        else
                        begin
                            temp_next = {item.write_data[2:0], temp_reg[11:10],
                                         item.write_data[7:3], temp_reg[4:0]};
                        end
                        first_next = ~first_reg;
                    end
                    REG_ADDRESS:
                    begin
                        if (first_reg)
                        begin
                            temp_next = {1'b0, item.write_data[5:0], temp_reg[7:0]};
                        end
                        else
                        begin
                            temp_next  = {temp_reg[14:8], item.write_data};
                            vaddr_next = {temp_reg[14:8], item.write_data};
                        end
                        first_next = ~first_reg;
                    end
                    REG_DATA:
                    begin
                        if (in_pal)
                        begin
                            pal_wr = 1'b1;
                        end
                        else
                        begin
                            vw = 1'b1;
                        end
                        vaddr_next = vaddr_step;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        spr_ctl           = spr_req;
        spr_ctl.load_addr = spr_req.load_addr & en;
        spr_ctl.write     = spr_req.write & en;
    end

    always_comb
    begin
        result.read_data            = rd;
        result.nmi_pulse            = nmi;
        result.vram_write           = vw;
        result.vram_write_address   = vw ? ext_addr : '0;
        result.vram_write_byte      = vw ? item.write_data : 8'h00;
        result.control_out          = control_next;
        result.mask_out             = mask_next;
        result.transfer_address_out = temp_next;
        result.current_address_out  = vaddr_next;
        result.fine_scroll_out      = fine_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg   <= 8'h00;
            control_reg <= 8'h00;
            mask_reg    <= 8'h00;
            vblank_reg  <= 1'b0;
            first_reg   <= 1'b1;
            temp_reg    <= '0;
            vaddr_reg   <= '0;
            fine_reg    <= 3'd0;
            buffer_reg  <= 8'h00;
            for (int i = 0; i < PAL_DEPTH; i++)
            begin
                pal_reg[i] <= 8'h00;
            end
        end
        else if (en)
        begin
            latch_reg   <= latch_next;
            control_reg <= control_next;
            mask_reg    <= mask_next;
            vblank_reg  <= vblank_next;
            first_reg   <= first_next;
            temp_reg    <= temp_next;
            vaddr_reg   <= vaddr_next;
            fine_reg    <= fine_next;
            buffer_reg  <= buffer_next;
            if (pal_wr)
            begin
                // Entries 0x10/0x14/0x18/0x1C mirror 0x00/0x04/0x08/0x0C.
                if (pal_mirror)
                begin
                    pal_reg[{1'b1, pal_idx[3:0]}] <= item.write_data;
                    pal_reg[{1'b0, pal_idx[3:0]}] <= item.write_data;
                end
                else
                begin
                    pal_reg[pal_idx] <= item.write_data;
                end
            end
        end
    end

endmodule

// ----- rtl/video_register_interface_top.sv -----
// ----------------------------------------------------------------------------
// Video register interface top level
// CPU-facing register file of the video unit: input register, register core
// with palette and sprite memory, and result register.
// ----------------------------------------------------------------------------
//
//   channel      dir  beat        content
//   bus_access   in   in_beat_t   one CPU access (read, write, none) plus
//                                 renderer events and status levels
//   result       out  out_beat_t  read byte, interrupt, external VRAM write,
//                                 register values after the access
//
// Each beat is held in the input register, where the register core handles
// it in a single pass, and then sits in the result register. A new beat can
// be taken every cycle while results are taken, so the sustained rate is one
// beat per clock; the result is registered after the core handles the beat.
// The sprite memory read is a look-ahead: its registered output always holds
// the entry at the current sprite address, which is what keeps the rate at one.
// Reset is asynchronous and active low; it returns the valid flags, the core
// registers, the palette and the sprite address and valid bits to their
// power-up values at once, with no sweep.
// When the result is not taken, the core holds and the input register stalls.
// ----------------------------------------------------------------------------
module video_register_interface_top
    import vri_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vri_in_if.sink     bus_access,
    vri_out_if.source  result
);

    logic      in_valid_reg;
    in_beat_t  in_data_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    logic      fire;
    spr_ctl_t  spr_ctl;
    logic [7:0] spr_rdata;
    out_beat_t core_result;

    // The core works on the held beat whenever the result register can take
    // its outcome: it is empty or its beat leaves in this same cycle.
    assign fire             = in_valid_reg && (!out_valid_reg || result.ready);
    assign bus_access.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (bus_access.ready)
        begin
            in_valid_reg <= bus_access.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bus_access.ready && bus_access.valid)
        begin
            in_data_reg <= bus_access.data;
        end
    end

    vri_sprite_mem u_sprite_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (spr_ctl),
        .rdata (spr_rdata)
    );

    vri_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (fire),
        .item      (in_data_reg),
        .spr_rdata (spr_rdata),
        .spr_ctl   (spr_ctl),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= core_result;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // A stalled input stage always holds a beat.
    a_ready_low_means_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !bus_access.ready |-> in_valid_reg
    ) else $error("input stage refused a beat while empty");

    // A new result only appears after the core handled a beat.
    a_result_from_fire: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire)
    ) else $error("result appeared without a processed beat");

    // External VRAM writes come only from a data register write.
    a_vram_write_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fire && core_result.vram_write) |->
            (in_data_reg.op == OP_WRITE && in_data_reg.reg_select == REG_DATA)
    ) else $error("VRAM write from an access that is not a data write");

    // Palette addresses never reach external VRAM.
    a_vram_write_not_palette: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.vram_write) |->
            (result.data.vram_write_address[13:8] != PAL_PAGE)
    ) else $error("palette access sent to external VRAM");

endmodule
